[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that pre implies post in the same cycle.
`define ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// Check that pre implies post in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

[rtl/core/dmt_pkg.sv]
// Shared types and constants of the disciplined millisecond timer.
`default_nettype none

package dmt_pkg;

	// Register indexes on the configuration port
	localparam logic REG_ADJUST_SPEED   = 1'b0;
	localparam logic REG_INITIAL_PERIOD = 1'b1;

	// Input item kinds carried in tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_UTC  = 1'b1;

	// Reset values and fixed constants
	localparam logic [15:0] ADJUST_SPEED_RST   = 16'd6554;
	localparam logic [15:0] INITIAL_PERIOD_RST = 16'd33240;
	localparam logic [16:0] Q16_ONE            = 17'h10000;
	localparam logic [9:0]  MS_PER_SEC         = 10'd1000;
	localparam logic [9:0]  MS_LAST            = 10'd999;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;   // any transaction taken this cycle
		logic tick;     // timer clock tick
		logic capture;  // first reference capture
		logic start;    // begin a period correction
		logic mul_d;    // form D = delta * 1000
		logic mul_t;    // form both weighted terms
		logic sum;      // add the weighted terms
		logic mul_n;    // scale by the current period
		logic sat_chk;  // saturation test, load divider
		logic div_step; // one restoring division step
		logic finish;   // commit the new period
	} dmt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic ref_valid; // a reference time is held
		logic utc_equal; // report equals the held reference
	} dmt_sts_t;

endpackage

`default_nettype wire

[rtl/core/disciplined_millisecond_timer.sv]
// Top level of the disciplined millisecond timer.
// A tick transaction (tuser 0) advances the prescaler and yields its result in the
// cycle after acceptance, so ticks stream at one per cycle while m_tready stays high.
// A UTC report (tuser 1) that only captures the reference, or repeats it, also
// yields its result in the next cycle. A report that corrects the period passes from
// acceptance to result through four multiply/add steps, a saturation check, a 16-step
// restoring divider and a commit; s_tready stays low during that time.
// The period is clamped to 1..65535. Writes to initial_period are accepted but
// only the reset value matters, since the period is loaded from it at reset.
`default_nettype none

module disciplined_millisecond_timer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] utc_seconds
	input  wire logic        s_tuser,  // [0] opcode
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata   // [31:0] millis_count, [54:32] seconds_count,
	                                   // [70:55] current_period, [71] ms_pulse,
	                                   // [72] period_adjusted, [79:73] zero
);

	logic [15:0]        adjust_speed_q;
	dmt_pkg::dmt_cmd_t  cmd;
	dmt_pkg::dmt_sts_t  sts;
	logic [31:0]        millis_count;
	logic [22:0]        seconds_count;
	logic [15:0]        current_period;
	logic               ms_pulse;
	logic               period_adjusted;

	// Hold the smoothing weight; initial_period writes have no effect after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_speed_q <= dmt_pkg::ADJUST_SPEED_RST;
		end else if (cfg_wen && (cfg_index == dmt_pkg::REG_ADJUST_SPEED)) begin
			adjust_speed_q <= cfg_data;
		end
	end

	dmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dmt_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.utc_seconds     (s_tdata),
		.adjust_speed    (adjust_speed_q),
		.millis_count    (millis_count),
		.seconds_count   (seconds_count),
		.current_period  (current_period),
		.ms_pulse        (ms_pulse),
		.period_adjusted (period_adjusted)
	);

	// Pack the result fields
	assign m_tdata = {7'b0, period_adjusted, ms_pulse, current_period,
		seconds_count, millis_count};

endmodule

`default_nettype wire

[rtl/core/dmt_ctrl.sv]
// Controller state machine: sequences ticks, captures and period corrections.
`default_nettype none

module dmt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_op,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire dmt_pkg::dmt_sts_t sts,
	output dmt_pkg::dmt_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_MUL_T,
		ST_SUM,
		ST_MUL_N,
		ST_SAT_CHK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       accept;
	logic       is_start;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign is_start  = accept && (in_op == dmt_pkg::OP_UTC) && sts.ref_valid && !sts.utc_equal;

	// Decode commands for the datapath
	always_comb begin
		cmd          = '0;
		cmd.accept   = accept;
		cmd.tick     = accept && (in_op == dmt_pkg::OP_TICK);
		cmd.capture  = accept && (in_op == dmt_pkg::OP_UTC) && !sts.ref_valid;
		cmd.start    = is_start;
		cmd.mul_d    = (state_q == ST_MUL_D);
		cmd.mul_t    = (state_q == ST_MUL_T);
		cmd.sum      = (state_q == ST_SUM);
		cmd.mul_n    = (state_q == ST_MUL_N);
		cmd.sat_chk  = (state_q == ST_SAT_CHK);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_DONE);
	end

	// Advance state, step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (is_start) begin
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_D:   state_q <= ST_MUL_T;
				ST_MUL_T:   state_q <= ST_SUM;
				ST_SUM:     state_q <= ST_MUL_N;
				ST_MUL_N:   state_q <= ST_SAT_CHK;
				ST_SAT_CHK: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'hF) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE:    state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase

			// Raise valid when an item completes, drop it once taken
			if ((accept && !is_start) || (state_q == ST_DONE)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/dmt_datapath.sv]
// Datapath: counters, reference capture and the period correction arithmetic.
`default_nettype none

module dmt_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dmt_pkg::dmt_cmd_t cmd,
	output dmt_pkg::dmt_sts_t      sts,
	input  wire logic [31:0]       utc_seconds,
	input  wire logic [15:0]       adjust_speed,
	output logic [31:0]            millis_count,
	output logic [22:0]            seconds_count,
	output logic [15:0]            current_period,
	output logic                   ms_pulse,
	output logic                   period_adjusted
);

	// Architectural state
	logic [15:0] prescale_q;
	logic [31:0] millis_q;
	logic [22:0] secs_q;
	logic [9:0]  sub_ms_q;
	logic [15:0] period_q;
	logic [31:0] ref_utc_q;
	logic [31:0] ref_millis_q;
	logic        pulse_q;
	logic        adjusted_q;

	// Correction arithmetic
	logic [31:0] delta_q;
	logic [31:0] elapsed_q;
	logic [41:0] d_q;
	logic [58:0] t1_q;
	logic [47:0] t2_q;
	logic [59:0] s_q;
	logic [59:0] n_q;
	logic [57:0] rem_q;
	logic [56:0] dv_q;
	logic [15:0] quo_q;
	logic        sat_q;

	logic        wrap;
	logic [75:0] prod_n;
	logic        take;
	logic [15:0] new_period;

	assign sts.ref_valid = (ref_utc_q != '0);
	assign sts.utc_equal = (utc_seconds == ref_utc_q);

	assign wrap   = (prescale_q >= period_q);
	assign prod_n = 76'(period_q) * 76'(s_q);
	assign take   = (rem_q >= {1'b0, dv_q});

	// Clamp the quotient to 1..65535
	always_comb begin
		priority if (sat_q) begin
			new_period = 16'hFFFF;
		end else if (quo_q == '0) begin
			new_period = 16'd1;
		end else begin
			new_period = quo_q;
		end
	end

	assign millis_count    = millis_q;
	assign seconds_count   = secs_q;
	assign current_period  = period_q;
	assign ms_pulse        = pulse_q;
	assign period_adjusted = adjusted_q;

	// Hold counters, period and references
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q   <= '0;
			millis_q     <= '0;
			secs_q       <= '0;
			sub_ms_q     <= '0;
			period_q     <= dmt_pkg::INITIAL_PERIOD_RST;
			ref_utc_q    <= '0;
			ref_millis_q <= '0;
			pulse_q      <= 1'b0;
			adjusted_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pulse_q    <= cmd.tick && wrap;
				adjusted_q <= 1'b0;
			end

			// Advance prescaler; on wrap count a millisecond
			if (cmd.tick) begin
				if (wrap) begin
					prescale_q <= '0;
					millis_q   <= millis_q + 32'd1;
					if (millis_q == '1) begin
						secs_q   <= '0;
						sub_ms_q <= '0;
					end else if (sub_ms_q == dmt_pkg::MS_LAST) begin
						secs_q   <= secs_q + 23'd1;
						sub_ms_q <= '0;
					end else begin
						sub_ms_q <= sub_ms_q + 10'd1;
					end
				end else begin
					prescale_q <= prescale_q + 16'd1;
				end
			end

			// Re-capture references on first report and on every correction
			if (cmd.capture || cmd.start) begin
				ref_utc_q    <= utc_seconds;
				ref_millis_q <= millis_q;
			end

			if (cmd.finish) begin
				period_q   <= new_period;
				adjusted_q <= (new_period != period_q);
			end
		end
	end

	// Period correction: multiply chain, then 16-step restoring division
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			delta_q   <= utc_seconds - ref_utc_q;
			elapsed_q <= millis_q - ref_millis_q;
		end
		if (cmd.mul_d) begin
			d_q <= 42'(delta_q) * 42'(dmt_pkg::MS_PER_SEC);
		end
		if (cmd.mul_t) begin
			t1_q <= 59'(dmt_pkg::Q16_ONE - {1'b0, adjust_speed}) * 59'(d_q);
			t2_q <= 48'(adjust_speed) * 48'(elapsed_q);
		end
		if (cmd.sum) begin
			s_q <= 60'(t1_q) + 60'(t2_q);
		end
		if (cmd.mul_n) begin
			n_q <= prod_n[75:16];
		end
		if (cmd.sat_chk) begin
			sat_q <= (n_q >= {2'b00, d_q, 16'h0000});
			rem_q <= n_q[57:0];
			dv_q  <= {d_q, 15'h0000};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (take) begin
				rem_q <= rem_q - {1'b0, dv_q};
			end
			quo_q <= {quo_q[14:0], take};
			dv_q  <= {1'b0, dv_q[56:1]};
		end
	end

endmodule

`default_nettype wire

[rtl/core/dmt_checker.sv]
// Port-level checks of the disciplined millisecond timer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dmt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata
);

	// A stalled result stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	// No new transaction is taken while a result is stalled
	`ASSERT_SAME(a_no_accept_stalled, m_tvalid && !m_tready, !s_tready)
	// A tick produces its result in the next cycle
	`ASSERT_NEXT(a_tick_result, s_tvalid && s_tready && !s_tuser, m_tvalid)

endmodule

bind disciplined_millisecond_timer dmt_checker u_dmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[sim/disciplined_millisecond_timer_test.sv]
// Self-checking testbench of the disciplined millisecond timer with a built-in predictor.
module disciplined_millisecond_timer_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 235;

	typedef struct packed {
		logic        opcode;
		logic [31:0] utc;
	} timer_item_t;

	// Result transaction as it sits on m_tdata, highest bits first
	typedef struct packed {
		logic [6:0]  pad;
		logic        adjusted;
		logic        pulse;
		logic [15:0] period;
		logic [22:0] seconds;
		logic [31:0] millis;
	} timer_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_index = dmt_pkg::REG_ADJUST_SPEED;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = dmt_pkg::OP_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	disciplined_millisecond_timer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Predicted timer state and the weight register
	logic [15:0] tick_phase = '0;
	logic [31:0] ms_total = '0;
	logic [15:0] ms_period = dmt_pkg::INITIAL_PERIOD_RST;
	logic [31:0] anchor_utc = '0;
	logic [31:0] anchor_ms = '0;
	logic [15:0] adjust_weight = dmt_pkg::ADJUST_SPEED_RST;

	timer_item_t   pending_items[$];
	timer_result_t expected_results[$];
	timer_item_t   drv_item;
	logic [31:0]   last_utc = '0;

	int failures = 0;
	int ticks_sent = 0;
	int reports_sent = 0;
	int pulses_seen = 0;
	int adjusts_seen = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int send_calm = 0;
	int stall_left = 0;
	int recv_calm = 0;
	bit drain_wait = 1'b0;

	initial forever #5 clk = ~clk;

	// Idle length for either side: mostly none or short, a few long, with calm stretches
	function automatic int idle_length(inout int calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 2) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Blend the old period toward the one implied by the measured milliseconds
	function automatic logic [15:0] corrected_period(input logic [15:0] period,
			input logic [15:0] weight, input logic [31:0] elapsed_ms,
			input logic [31:0] delta_s);
		logic [127:0] span;
		logic [127:0] blend;
		logic [127:0] quotient;
		span = 128'(delta_s) * 128'd1000;
		blend = (128'd65536 - 128'(weight)) * span + 128'(weight) * 128'(elapsed_ms);
		quotient = (blend * 128'(period)) / (span << 16);
		if (quotient > 128'd65535)
			return 16'hFFFF;
		if (quotient == '0)
			return 16'd1;
		return quotient[15:0];
	endfunction

	// Advance the predicted timer by one accepted transaction and store its result
	task automatic timer_advance(input timer_item_t item);
		timer_result_t res;
		logic [15:0] next_period;
		res = '0;
		if (item.opcode == dmt_pkg::OP_TICK) begin
			if (tick_phase >= ms_period) begin
				tick_phase = '0;
				ms_total = ms_total + 32'd1;
				res.pulse = 1'b1;
			end else begin
				tick_phase = tick_phase + 16'd1;
			end
		end else if (anchor_utc == '0) begin
			anchor_utc = item.utc;
			anchor_ms = ms_total;
		end else if (item.utc != anchor_utc) begin
			next_period = corrected_period(ms_period, adjust_weight, ms_total - anchor_ms,
				item.utc - anchor_utc);
			res.adjusted = (next_period != ms_period);
			ms_period = next_period;
			anchor_utc = item.utc;
			anchor_ms = ms_total;
		end
		res.millis = ms_total;
		res.seconds = 23'(ms_total / 32'd1000);
		res.period = ms_period;
		expected_results.push_back(res);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// Driver: present queued transactions, with random gaps and an occasional full drain
	always @(posedge clk or negedge arst_n)
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= dmt_pkg::OP_TICK;
			gap_left = 0;
			drain_wait = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				timer_advance(drv_item);
				if (drv_item.opcode == dmt_pkg::OP_TICK)
					ticks_sent++;
				else
					reports_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (drain_wait && expected_results.size() == 0)
					drain_wait = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (!drain_wait && pending_items.size() > 0) begin
					drv_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= drv_item.utc;
					s_tuser <= drv_item.opcode;
					gap_left = idle_length(send_calm);
					if ($urandom_range(0, 199) == 0 || ticks_sent + reports_sent == 400)
						drain_wait = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end

	// Monitor: check each result transaction against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n)
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, m_tdata);
					failures++;
				end else begin
					timer_result_t want;
					timer_result_t got;
					want = expected_results.pop_front();
					got = m_tdata;
					compare_field("millis_count", want.millis, got.millis);
					compare_field("seconds_count", 32'(want.seconds), 32'(got.seconds));
					compare_field("current_period", 32'(want.period), 32'(got.period));
					compare_field("ms_pulse", 32'(want.pulse), 32'(got.pulse));
					compare_field("period_adjusted", 32'(want.adjusted), 32'(got.adjusted));
					pulses_seen += got.pulse;
					adjusts_seen += got.adjusted;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = idle_length(recv_calm);
			end
		end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
			expected_results.size());
		$display("TEST FAILED");
		$finish;
	end

	task automatic queue_item(input logic opcode, input logic [31:0] utc);
		timer_item_t item;
		item.opcode = opcode;
		item.utc = utc;
		if (opcode == dmt_pkg::OP_UTC)
			last_utc = utc;
		pending_items.push_back(item);
	endtask

	task automatic queue_ticks(input int count);
		for (int i = 0; i < count; i++)
			queue_item(dmt_pkg::OP_TICK, $urandom);
	endtask

	// Hold until every queued transaction has gone through and its result has come back
	task automatic wait_for_drain();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic index, input logic [15:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		// initial_period only matters at reset, which is never repeated
		if (index == dmt_pkg::REG_ADJUST_SPEED)
			adjust_weight = value;
	endtask

	task automatic queue_random_phase();
		int roll;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				roll = $urandom_range(0, 99);
				if (roll < 50)
					queue_item(dmt_pkg::OP_UTC, last_utc + $urandom_range(1, 3));
				else if (roll < 65)
					queue_item(dmt_pkg::OP_UTC, last_utc);
				else if (roll < 75)
					queue_item(dmt_pkg::OP_UTC, '0);
				else if (roll < 85)
					queue_item(dmt_pkg::OP_UTC, last_utc - $urandom_range(1, 5));
				else
					queue_item(dmt_pkg::OP_UTC, $urandom);
			end else begin
				queue_item(dmt_pkg::OP_TICK, $urandom);
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_register(dmt_pkg::REG_INITIAL_PERIOD, 16'hFFFF);

		// Reference handling at the default weight: zero report, all-ones capture,
		// equal report, wrap to zero, recapture, time going backwards
		queue_ticks(2);
		queue_item(dmt_pkg::OP_UTC, 32'h0);
		queue_item(dmt_pkg::OP_UTC, 32'hFFFF_FFFF);
		queue_item(dmt_pkg::OP_UTC, 32'hFFFF_FFFF);
		queue_ticks(1);
		queue_item(dmt_pkg::OP_UTC, 32'h0);
		queue_item(dmt_pkg::OP_UTC, 32'h0);
		queue_item(dmt_pkg::OP_UTC, 32'd7);
		queue_ticks(1);
		queue_item(dmt_pkg::OP_UTC, 32'd3);
		wait_for_drain();

		// Heavy weight pulls the period down to a few dozen ticks
		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'd65408);
		queue_ticks(1);
		queue_item(dmt_pkg::OP_UTC, last_utc + 32'd1);
		wait_for_drain();

		// Random phases at varied weights
		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'($urandom_range(1, 3000)));
		write_register(dmt_pkg::REG_INITIAL_PERIOD, 16'd1);
		queue_random_phase();
		wait_for_drain();

		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'd0);
		queue_random_phase();
		wait_for_drain();

		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'($urandom_range(1, 3000)));
		write_register(dmt_pkg::REG_INITIAL_PERIOD, 16'($urandom_range(1, 65535)));
		queue_random_phase();
		wait_for_drain();

		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'($urandom_range(0, 65535)));
		queue_random_phase();
		wait_for_drain();

		// Full weight with no elapsed milliseconds clamps the period to one,
		// below the running prescale count
		write_register(dmt_pkg::REG_ADJUST_SPEED, 16'hFFFF);
		queue_ticks(3);
		queue_item(dmt_pkg::OP_UTC, last_utc + 32'd1);
		queue_item(dmt_pkg::OP_UTC, last_utc + 32'd1);
		queue_ticks(5);
		wait_for_drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d ticks and %0d UTC reports over seven weight settings,",
			ticks_sent, reports_sent);
		$display("with %0d millisecond pulses and %0d period corrections; final period %0d.",
			pulses_seen, adjusts_seen, ms_period);
		if (failures == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
